### rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants, codes and types of the 3x3 RGB box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_SIZE_DEF     = 512;
  localparam int CHANNEL_BITS_DEF = 16;

  // Fixed widths of the ports.
  localparam int PORT_W     = 16;
  localparam int CFG_W      = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register map: the word index is paddr[CFG_ADDR_W-1:2].
  localparam logic [CFG_ADDR_W-3:0] REG_IMAGE_SIZE = '0;
  localparam logic [CFG_W-1:0]      IMAGE_SIZE_RST = 10'd512;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Input action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef enum logic {
    ITEM_PIXEL,
    ITEM_DRAIN
  } item_kind_t;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_sel_t;

  // Classification of one word, produced by the front and used by the back.
  typedef struct packed {
    item_kind_t kind;
    logic       row_top;   // output row is the top frame row
    logic       emit0;     // pixel gives its first result
    logic       emit1;     // pixel closes a row and gives a second result
    logic       col_full;  // first result spans three columns
    logic       row_end;   // pixel is the last one of its row
    logic       d_first;   // drain word for the left column
    logic       d_end;     // drain word for the right column
  } item_ctl_t;

endpackage

### rtl/box_filter_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb: 3x3 mean filter over a square RGB frame
// A result passes the front stage, the queue, the sum stage and the output
// register, and waits longer while earlier words sit in the queue. Throughput:
// one word per cycle in bursts unless a full queue or a result stall holds it
// off; a row-end pixel below the top row holds the back for its second result.
// Reset: positions clear, image_size reads 512; line memories are not cleared.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb #(
  parameter int  MAX_SIZE     = bf3_pkg::MAX_SIZE_DEF,
  parameter int  CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bf3_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bf3_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [bf3_pkg::PORT_W-1:0]     in_red,
  input  logic [bf3_pkg::PORT_W-1:0]     in_green,
  input  logic [bf3_pkg::PORT_W-1:0]     in_blue,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bf3_pkg::PORT_W-1:0]     out_red,
  output logic [bf3_pkg::PORT_W-1:0]     out_green,
  output logic [bf3_pkg::PORT_W-1:0]     out_blue,
  output logic                           out_run_last,
  output logic                           out_frame_end
);

  localparam int POS_W   = $clog2(MAX_SIZE);
  localparam int DIM_W   = $clog2(MAX_SIZE + 1);
  localparam int EXT_W   = (DIM_W > bf3_pkg::CFG_W) ? DIM_W : bf3_pkg::CFG_W;
  localparam int COL_W   = CHANNEL_BITS + 2;
  localparam int CNT_W   = $clog2(bf3_pkg::QUEUE_DEPTH + 1);
  localparam int ENTRY_W = $bits(bf3_pkg::item_ctl_t) + 6 * COL_W;

  logic [bf3_pkg::CFG_W-1:0] image_size_r;
  logic                      reg_hit, cfg_wr, restart;
  logic [EXT_W-1:0]          size_ext, dim;
  logic [POS_W-1:0]          frame_last;

  logic                         mem_we, mem_wbank;
  logic [POS_W-1:0]             mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [2:0][CHANNEL_BITS-1:0] mem_wdata, rd0_a, rd0_b, rd1_a, rd1_b;

  logic                  q_push, q_pop, q_empty;
  logic [CNT_W-1:0]      q_count;
  bf3_pkg::item_ctl_t    push_ctl, q_ctl;
  logic [2:0][COL_W-1:0] push_sum_a, push_sum_b, q_sum_a, q_sum_b;
  logic [ENTRY_W-1:0]    push_data, pop_data;

  // Register access: a write to image_size also starts a new frame.
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[bf3_pkg::CFG_ADDR_W-1:2] == bf3_pkg::REG_IMAGE_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign restart    = cfg_wr && reg_hit;
  assign cfg_prdata = reg_hit ? bf3_pkg::CFG_DATA_W'(image_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= bf3_pkg::IMAGE_SIZE_RST;
    end else if (restart) begin
      image_size_r <= cfg_pwdata[bf3_pkg::CFG_W-1:0];
    end
  end

  // Frame size clamped to the supported range.
  always_comb begin
    size_ext = EXT_W'(image_size_r);
    if (size_ext < EXT_W'(2)) begin
      dim = EXT_W'(2);
    end else if (size_ext > EXT_W'(MAX_SIZE)) begin
      dim = EXT_W'(MAX_SIZE);
    end else begin
      dim = size_ext;
    end
  end
  assign frame_last = POS_W'(dim - 1'b1);

  bf3_front #(
    .MAX_SIZE     (MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .restart     (restart),
    .frame_last  (frame_last),
    .q_count     (q_count),
    .mem_we      (mem_we),
    .mem_wbank   (mem_wbank),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .rd0_a       (rd0_a),
    .rd0_b       (rd0_b),
    .rd1_a       (rd1_a),
    .rd1_b       (rd1_b),
    .push_vld    (q_push),
    .push_ctl    (push_ctl),
    .push_sum_a  (push_sum_a),
    .push_sum_b  (push_sum_b)
  );

  bf3_linebuf #(
    .MAX_SIZE     (MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_linebuf (
    .clk     (clk),
    .we      (mem_we),
    .wbank   (mem_wbank),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rd0_a   (rd0_a),
    .rd0_b   (rd0_b),
    .rd1_a   (rd1_a),
    .rd1_b   (rd1_b)
  );

  // Queue entries carry the classification and both column sums.
  assign push_data = {push_ctl, push_sum_a, push_sum_b};
  assign {q_ctl, q_sum_a, q_sum_b} = pop_data;

  bf3_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (bf3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  bf3_back #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctl         (q_ctl),
    .q_sum_a       (q_sum_a),
    .q_sum_b       (q_sum_b),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

  // A word pushed into the queue always finds a free entry.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < CNT_W'(bf3_pkg::QUEUE_DEPTH)))
    else $error("queue push without a free entry");

  // The back never takes a word from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A full queue holds the input side off.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == CNT_W'(bf3_pkg::QUEUE_DEPTH)) |-> in_stall)
    else $error("input taken while queue is full");

  // The frame's last pixel is always the last result of its word.
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_run_last)
    else $error("frame end on a result that is not the last one");

endmodule

### rtl/bf3_linebuf.sv
// ----------------------------------------------------------------------------
// bf3_linebuf
// Two line memories of one row each. The bank select picks the one that
// holds the upper row; the other holds the middle row. Each memory has one
// write port and two registered read ports.
// ----------------------------------------------------------------------------
module bf3_linebuf #(
  parameter int  MAX_SIZE     = bf3_pkg::MAX_SIZE_DEF,
  parameter int  CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF,
  localparam int POS_W        = $clog2(MAX_SIZE)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         wbank,
  input  logic [POS_W-1:0]             waddr,
  input  logic [2:0][CHANNEL_BITS-1:0] wdata,
  input  logic [POS_W-1:0]             raddr_a,
  input  logic [POS_W-1:0]             raddr_b,
  output logic [2:0][CHANNEL_BITS-1:0] rd0_a,
  output logic [2:0][CHANNEL_BITS-1:0] rd0_b,
  output logic [2:0][CHANNEL_BITS-1:0] rd1_a,
  output logic [2:0][CHANNEL_BITS-1:0] rd1_b
);

  logic [2:0][CHANNEL_BITS-1:0] mem0 [MAX_SIZE];
  logic [2:0][CHANNEL_BITS-1:0] mem1 [MAX_SIZE];

  // Bank 0: write first in code order, reads return the old contents.
  always_ff @(posedge clk) begin
    if (we && !wbank) begin
      mem0[waddr] <= wdata;
    end
    rd0_a <= mem0[raddr_a];
    rd0_b <= mem0[raddr_b];
  end

  // Bank 1.
  always_ff @(posedge clk) begin
    if (we && wbank) begin
      mem1[waddr] <= wdata;
    end
    rd1_a <= mem1[raddr_a];
    rd1_b <= mem1[raddr_b];
  end

endmodule

### rtl/bf3_queue.sv
// ----------------------------------------------------------------------------
// bf3_queue
// Small first-in first-out queue of classified words between the front and
// the back of the filter.
// ----------------------------------------------------------------------------
module bf3_queue #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = bf3_pkg::QUEUE_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

### rtl/bf3_front.sv
// ----------------------------------------------------------------------------
// bf3_front
// Accepts input words, tracks row, column and drain positions, drives the
// line memories and forms the column sums that go into the queue.
// ----------------------------------------------------------------------------
module bf3_front #(
  parameter int  MAX_SIZE     = bf3_pkg::MAX_SIZE_DEF,
  parameter int  CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF,
  localparam int POS_W        = $clog2(MAX_SIZE),
  localparam int COL_W        = CHANNEL_BITS + 2,
  localparam int CNT_W        = $clog2(bf3_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [bf3_pkg::PORT_W-1:0]   in_red,
  input  logic [bf3_pkg::PORT_W-1:0]   in_green,
  input  logic [bf3_pkg::PORT_W-1:0]   in_blue,
  // frame control
  input  logic                         restart,
  input  logic [POS_W-1:0]             frame_last,
  input  logic [CNT_W-1:0]             q_count,
  // line memories
  output logic                         mem_we,
  output logic                         mem_wbank,
  output logic [POS_W-1:0]             mem_waddr,
  output logic [2:0][CHANNEL_BITS-1:0] mem_wdata,
  output logic [POS_W-1:0]             mem_raddr_a,
  output logic [POS_W-1:0]             mem_raddr_b,
  input  logic [2:0][CHANNEL_BITS-1:0] rd0_a,
  input  logic [2:0][CHANNEL_BITS-1:0] rd0_b,
  input  logic [2:0][CHANNEL_BITS-1:0] rd1_a,
  input  logic [2:0][CHANNEL_BITS-1:0] rd1_b,
  // queue push side
  output logic                         push_vld,
  output bf3_pkg::item_ctl_t           push_ctl,
  output logic [2:0][COL_W-1:0]        push_sum_a,
  output logic [2:0][COL_W-1:0]        push_sum_b
);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] drn_r, drn_nxt;
  logic             pend_r, pend_nxt;
  logic             bank_r, bank_nxt;

  logic                         st_vld_r;
  bf3_pkg::item_ctl_t           st_ctl_r, ctl_nxt;
  logic [2:0][CHANNEL_BITS-1:0] st_cur_r, cur;
  logic                         st_bank_r;

  logic acc, is_pix, is_drn, row_end, d_end;

  // Only the low channel bits of a pixel are kept.
  assign cur = {in_red[CHANNEL_BITS-1:0], in_green[CHANNEL_BITS-1:0],
                in_blue[CHANNEL_BITS-1:0]};

  // The queue must hold every word in flight, including the one in the stage.
  assign in_stall = ({1'b0, q_count} + (CNT_W + 1)'(st_vld_r))
                    >= (CNT_W + 1)'(bf3_pkg::QUEUE_DEPTH);

  assign acc     = in_valid && !in_stall;
  assign is_pix  = (in_action == bf3_pkg::ACT_PIXEL) && !pend_r;
  assign is_drn  = (in_action == bf3_pkg::ACT_DRAIN) && pend_r;
  assign row_end = (col_r == frame_last);
  assign d_end   = (drn_r == frame_last);

  // Classification and position update.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    drn_nxt  = drn_r;
    pend_nxt = pend_r;
    bank_nxt = bank_r;
    ctl_nxt  = '0;
    ctl_nxt.kind = is_drn ? bf3_pkg::ITEM_DRAIN : bf3_pkg::ITEM_PIXEL;
    if (is_pix) begin
      ctl_nxt.row_top  = ((row_r >> 1) == '0);
      ctl_nxt.emit0    = (row_r != '0) && (col_r != '0);
      ctl_nxt.emit1    = (row_r != '0) && row_end;
      ctl_nxt.col_full = ((col_r >> 1) != '0);
      ctl_nxt.row_end  = row_end;
    end else begin
      ctl_nxt.d_first = (drn_r == '0);
      ctl_nxt.d_end   = d_end;
    end
    if (acc && is_pix) begin
      if (row_end) begin
        col_nxt  = '0;
        bank_nxt = !bank_r;
        if (row_r == frame_last) begin
          row_nxt  = '0;
          pend_nxt = 1'b1;
          drn_nxt  = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (acc && is_drn) begin
      if (d_end) begin
        pend_nxt = 1'b0;
        drn_nxt  = '0;
      end else begin
        drn_nxt = drn_r + 1'b1;
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      drn_r    <= '0;
      pend_r   <= 1'b0;
      bank_r   <= 1'b0;
      st_vld_r <= 1'b0;
    end else if (restart) begin
      col_r    <= '0;
      row_r    <= '0;
      drn_r    <= '0;
      pend_r   <= 1'b0;
      st_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      drn_r    <= drn_nxt;
      pend_r   <= pend_nxt;
      bank_r   <= bank_nxt;
      st_vld_r <= acc && (is_pix || is_drn);
    end
  end

  // Stage payload, aligned with the registered memory read data.
  always_ff @(posedge clk) begin
    if (acc) begin
      st_ctl_r  <= ctl_nxt;
      st_cur_r  <= is_pix ? cur : '0;
      st_bank_r <= bank_r;
    end
  end

  // Memory access: a pixel reads its column and overwrites the upper row;
  // a drain word reads its own column and the one to its right.
  assign mem_we      = acc && is_pix;
  assign mem_wbank   = bank_r;
  assign mem_waddr   = col_r;
  assign mem_wdata   = cur;
  assign mem_raddr_a = pend_r ? drn_r + 1'b1 : col_r;
  assign mem_raddr_b = drn_r;

  // Column sums: upper (unless top row), middle and incoming pixel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      push_sum_a[ch] =
        COL_W'(st_ctl_r.row_top ? '0 : (st_bank_r ? rd1_a[ch] : rd0_a[ch]))
        + COL_W'(st_bank_r ? rd0_a[ch] : rd1_a[ch])
        + COL_W'(st_cur_r[ch]);
      push_sum_b[ch] = COL_W'(rd0_b[ch]) + COL_W'(rd1_b[ch]);
    end
  end

  assign push_vld = st_vld_r;
  assign push_ctl = st_ctl_r;

endmodule

### rtl/bf3_back.sv
// ----------------------------------------------------------------------------
// bf3_back
// Takes classified words from the queue, keeps the column sums of the
// window, builds the neighbourhood sums and divides them by 4, 6 or 9.
// ----------------------------------------------------------------------------
module bf3_back #(
  parameter int  CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF,
  localparam int COL_W        = CHANNEL_BITS + 2,
  localparam int SUM_W        = CHANNEL_BITS + 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // queue pop side
  input  logic                       q_empty,
  input  bf3_pkg::item_ctl_t         q_ctl,
  input  logic [2:0][COL_W-1:0]      q_sum_a,
  input  logic [2:0][COL_W-1:0]      q_sum_b,
  output logic                       q_pop,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bf3_pkg::PORT_W-1:0] out_red,
  output logic [bf3_pkg::PORT_W-1:0] out_green,
  output logic [bf3_pkg::PORT_W-1:0] out_blue,
  output logic                       out_run_last,
  output logic                       out_frame_end
);

  // Reciprocals, exact for every sum below 2**SUM_W.
  localparam int     RECIP_K = SUM_W + 4;
  localparam int     MUL_W   = RECIP_K - 2;
  localparam int     PROD_W  = SUM_W + MUL_W;
  localparam longint M6      = ((longint'(1) << RECIP_K) + 5) / 6;
  localparam longint M9      = ((longint'(1) << RECIP_K) + 8) / 9;
  localparam logic [MUL_W-1:0] RECIP_6 = MUL_W'(M6);
  localparam logic [MUL_W-1:0] RECIP_9 = MUL_W'(M9);

  logic adv;

  // Window column sums and drain history.
  logic [2:0][COL_W-1:0] cs1_r, cs1_nxt;
  logic [2:0][COL_W-1:0] cs2_r, cs2_nxt;
  logic [2:0][COL_W-1:0] prev_r, prev_nxt;
  logic                  pend1_r, pend1_nxt;
  logic                  top1_r, top1_nxt;

  // Sum stage.
  logic                  w_vld_r, w_vld_nxt;
  logic [2:0][SUM_W-1:0] w_sum_r, w_sum_nxt;
  bf3_pkg::div_sel_t     w_div_r, w_div_nxt;
  logic                  w_last_r, w_last_nxt;
  logic                  w_fend_r, w_fend_nxt;

  // Output register.
  logic                              out_vld_r;
  logic [2:0][bf3_pkg::PORT_W-1:0]   out_px_r;
  logic                              out_last_r;
  logic                              out_fend_r;

  logic [PROD_W-1:0]            prod6 [3];
  logic [PROD_W-1:0]            prod9 [3];
  logic [2:0][CHANNEL_BITS-1:0] quot;

  // The whole back advances when the output register can take a word.
  assign adv   = !out_vld_r || !out_stall;
  assign q_pop = adv && !pend1_r && !q_empty;

  // Window update and neighbourhood sum.
  always_comb begin
    w_vld_nxt  = 1'b0;
    w_sum_nxt  = w_sum_r;
    w_div_nxt  = w_div_r;
    w_last_nxt = w_last_r;
    w_fend_nxt = w_fend_r;
    cs1_nxt    = cs1_r;
    cs2_nxt    = cs2_r;
    prev_nxt   = prev_r;
    pend1_nxt  = pend1_r;
    top1_nxt   = top1_r;
    if (pend1_r) begin
      // Second result at row end: the two rightmost columns.
      w_vld_nxt = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
        w_sum_nxt[ch] = SUM_W'(cs1_r[ch]) + SUM_W'(cs2_r[ch]);
      end
      w_div_nxt  = top1_r ? bf3_pkg::DIV_BY_4 : bf3_pkg::DIV_BY_6;
      w_last_nxt = 1'b1;
      w_fend_nxt = 1'b0;
      pend1_nxt  = 1'b0;
    end else if (!q_empty) begin
      unique case (q_ctl.kind)
        bf3_pkg::ITEM_PIXEL: begin
          w_vld_nxt = q_ctl.emit0;
          for (int ch = 0; ch < 3; ch++) begin
            w_sum_nxt[ch] = SUM_W'(q_sum_a[ch]) + SUM_W'(cs2_r[ch])
                            + SUM_W'(q_ctl.col_full ? cs1_r[ch] : '0);
          end
          unique case ({q_ctl.col_full, q_ctl.row_top})
            2'b10:   w_div_nxt = bf3_pkg::DIV_BY_9;
            2'b01:   w_div_nxt = bf3_pkg::DIV_BY_4;
            default: w_div_nxt = bf3_pkg::DIV_BY_6;
          endcase
          w_last_nxt = !q_ctl.row_end;
          w_fend_nxt = 1'b0;
          cs1_nxt    = cs2_r;
          cs2_nxt    = q_sum_a;
          pend1_nxt  = q_ctl.emit1;
          top1_nxt   = q_ctl.row_top;
        end
        bf3_pkg::ITEM_DRAIN: begin
          // Bottom row: previous, own and right column of the last two rows.
          w_vld_nxt = 1'b1;
          for (int ch = 0; ch < 3; ch++) begin
            w_sum_nxt[ch] = SUM_W'(q_sum_b[ch])
                            + SUM_W'(q_ctl.d_first ? '0 : prev_r[ch])
                            + SUM_W'(q_ctl.d_end ? '0 : q_sum_a[ch]);
          end
          w_div_nxt  = (q_ctl.d_first || q_ctl.d_end) ? bf3_pkg::DIV_BY_4
                                                      : bf3_pkg::DIV_BY_6;
          w_last_nxt = 1'b1;
          w_fend_nxt = q_ctl.d_end;
          prev_nxt   = q_sum_b;
        end
      endcase
    end
  end

  // Division by reciprocal multiplication.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod6[ch] = PROD_W'(w_sum_r[ch]) * PROD_W'(RECIP_6);
      prod9[ch] = PROD_W'(w_sum_r[ch]) * PROD_W'(RECIP_9);
      unique case (w_div_r)
        bf3_pkg::DIV_BY_4: quot[ch] = w_sum_r[ch][2 +: CHANNEL_BITS];
        bf3_pkg::DIV_BY_6: quot[ch] = prod6[ch][RECIP_K +: CHANNEL_BITS];
        bf3_pkg::DIV_BY_9: quot[ch] = prod9[ch][RECIP_K +: CHANNEL_BITS];
        default:           quot[ch] = '0;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r   <= 1'b0;
      pend1_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      w_vld_r   <= w_vld_nxt;
      pend1_r   <= pend1_nxt;
      out_vld_r <= w_vld_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      cs1_r    <= cs1_nxt;
      cs2_r    <= cs2_nxt;
      prev_r   <= prev_nxt;
      top1_r   <= top1_nxt;
      w_sum_r  <= w_sum_nxt;
      w_div_r  <= w_div_nxt;
      w_last_r <= w_last_nxt;
      w_fend_r <= w_fend_nxt;
      for (int ch = 0; ch < 3; ch++) begin
        out_px_r[ch] <= bf3_pkg::PORT_W'(quot[ch]);
      end
      out_last_r <= w_last_r;
      out_fend_r <= w_fend_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_red       = out_px_r[2];
  assign out_green     = out_px_r[1];
  assign out_blue      = out_px_r[0];
  assign out_run_last  = out_last_r;
  assign out_frame_end = out_fend_r;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the 3x3 RGB box filter
// A driver streams pixel and drain words in random bursts while the result
// side stalls on a pattern of its own. Every accepted word runs through a
// local model of the filter, line memories included, and the averaged
// pixels it forecasts are compared field by field with the block's output.
// Frame sizes are reconfigured between phases, extremes and clamping included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bf3_pkg::*;

  localparam int          LINE_MAX    = MAX_SIZE_DEF;
  localparam int          ITEM_TARGET = 1050;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          SETTLE_CYC  = 8;
  localparam logic [CFG_ADDR_W-3:0] REG_UNUSED = 1'b1;

  // One word on the input channel; hold makes the driver wait for the
  // result queue to run dry before sending it.
  typedef struct {
    logic        action;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    bit          hold;
  } pixel_word_t;

  // One averaged output pixel.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        run_last;
    logic        frame_end;
  } avg_px_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_psel      = 1'b0;
  logic                  cfg_penable   = 1'b0;
  logic                  cfg_pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr     = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata    = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic                  in_action     = ACT_PIXEL;
  logic [PORT_W-1:0]     in_red        = '0;
  logic [PORT_W-1:0]     in_green      = '0;
  logic [PORT_W-1:0]     in_blue       = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [PORT_W-1:0]     out_red;
  logic [PORT_W-1:0]     out_green;
  logic [PORT_W-1:0]     out_blue;
  logic                  out_run_last;
  logic                  out_frame_end;

  box_filter_3x3_rgb u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_run_last (out_run_last),
    .out_frame_end(out_frame_end)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pixel_word_t send_q[$];
  avg_px_t     avg_q[$];
  int          err_cnt    = 0;
  int          word_total = 0;
  logic        in_taken   = 1'b0;
  bit          cfg_taken  = 1'b0;

  // --------------------------------------------------------------------------
  // Filter model state
  // --------------------------------------------------------------------------
  logic [9:0]  size_reg   = IMAGE_SIZE_RST;
  int unsigned row_pos    = 0;
  int unsigned col_pos    = 0;
  int unsigned drain_pos  = 0;
  bit          drain_pend = 1'b0;
  // Two line memories; up_sel picks the one holding the upper row.
  logic [47:0] line_mem [2][LINE_MAX];
  bit          up_sel     = 1'b0;
  // Window: [column oldest..newest][upper, middle, incoming].
  logic [47:0] win [3][3];

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      line_mem[0][i] = '0;
      line_mem[1][i] = '0;
    end
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) win[j][i] = '0;
  end

  function automatic int unsigned clamp_dim(input logic [9:0] v);
    int unsigned n;
    n = v;
    if (n < 2) n = 2;
    if (n > LINE_MAX) n = LINE_MAX;
    return n;
  endfunction

  function automatic avg_px_t px_mean(input int unsigned s_r, s_g, s_b, cnt,
                                      input logic last, fend);
    avg_px_t p;
    p.red       = 16'(s_r / cnt);
    p.green     = 16'(s_g / cnt);
    p.blue      = 16'(s_b / cnt);
    p.run_last  = last;
    p.frame_end = fend;
    return p;
  endfunction

  // Mean over the window columns from col_lo and rows from row_lo.
  function automatic avg_px_t window_mean(input int unsigned col_lo, row_lo,
                                          input logic last);
    int unsigned s_r, s_g, s_b, cnt;
    s_r = 0; s_g = 0; s_b = 0; cnt = 0;
    for (int unsigned j = col_lo; j < 3; j++)
      for (int unsigned i = row_lo; i < 3; i++) begin
        s_r += win[j][i][47:32];
        s_g += win[j][i][31:16];
        s_b += win[j][i][15:0];
        cnt++;
      end
    return px_mean(s_r, s_g, s_b, cnt, last, 1'b0);
  endfunction

  // Register write: a size write starts a new frame.
  task automatic size_apply(input logic [CFG_ADDR_W-3:0] idx, input logic [9:0] val);
    if (idx == REG_IMAGE_SIZE) begin
      size_reg   = val;
      row_pos    = 0;
      col_pos    = 0;
      drain_pos  = 0;
      drain_pend = 1'b0;
    end
  endtask

  // Forecast the averaged pixels one accepted word gives.
  task automatic filter_predict(input logic act, input logic [15:0] r_in, g_in, b_in);
    int unsigned dim, lo, hi, d, r, c, row_lo, s_r, s_g, s_b;
    logic [47:0] cur;
    dim = clamp_dim(size_reg);
    if (col_pos >= dim) col_pos = 0;
    if (row_pos >= dim) row_pos = 0;
    if (drain_pos >= dim) drain_pos = 0;

    if (act == ACT_DRAIN) begin
      if (!drain_pend) return;
      // Bottom row: two rows deep, clipped at left and right.
      d  = drain_pos;
      lo = (d >= 1) ? d - 1 : d;
      hi = (d + 1 < dim) ? d + 1 : d;
      s_r = 0; s_g = 0; s_b = 0;
      for (int unsigned j = lo; j <= hi; j++) begin
        s_r += line_mem[up_sel][j][47:32] + line_mem[!up_sel][j][47:32];
        s_g += line_mem[up_sel][j][31:16] + line_mem[!up_sel][j][31:16];
        s_b += line_mem[up_sel][j][15:0]  + line_mem[!up_sel][j][15:0];
      end
      avg_q.push_back(px_mean(s_r, s_g, s_b, 2 * (hi - lo + 1), 1'b1, d == dim - 1));
      if (d == dim - 1) begin
        drain_pend = 1'b0;
        drain_pos  = 0;
      end else begin
        drain_pos = d + 1;
      end
    end else begin
      if (drain_pend) return;
      r      = row_pos;
      c      = col_pos;
      row_lo = (r >= 2) ? 0 : 1;
      cur    = {r_in, g_in, b_in};
      // Shift the window and bring in the new column.
      win[0] = win[1];
      win[1] = win[2];
      win[2][0] = line_mem[up_sel][c];
      win[2][1] = line_mem[!up_sel][c];
      win[2][2] = cur;
      line_mem[up_sel][c] = cur;

      if (r >= 1 && c >= 1)
        avg_q.push_back(window_mean((c >= 2) ? 0 : 1, row_lo, c != dim - 1));
      if (r >= 1 && c == dim - 1)
        avg_q.push_back(window_mean(1, row_lo, 1'b1));

      // Row end: the memories trade places.
      c++;
      if (c >= dim) begin
        up_sel = !up_sel;
        c = 0;
        r++;
        if (r >= dim) begin
          r          = 0;
          drain_pend = 1'b1;
          drain_pos  = 0;
        end
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_result();
    avg_px_t got, want;
    got = '{out_red, out_green, out_blue, out_run_last, out_frame_end};
    if (avg_q.size() == 0) begin
      flag_error($sformatf("unexpected pixel r=%h g=%h b=%h last=%b fend=%b",
                           got.red, got.green, got.blue, got.run_last, got.frame_end));
    end else begin
      want = avg_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.run_last !== want.run_last || got.frame_end !== want.frame_end)
        flag_error($sformatf({"pixel mismatch: exp r=%h g=%h b=%h last=%b fend=%b, ",
                              "got r=%h g=%h b=%h last=%b fend=%b"},
                             want.red, want.green, want.blue, want.run_last, want.frame_end,
                             got.red, got.green, got.blue, got.run_last, got.frame_end));
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the new word is forecast, so a
  // stray result can never match an expectation made in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) check_result();
    if (rst_n && in_valid && !in_stall) filter_predict(in_action, in_red, in_green, in_blue);
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of words with random gaps between them.
  // --------------------------------------------------------------------------
  int          gap_left   = 0;
  int          burst_left = 0;
  pixel_word_t nxt;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (send_q.size() != 0 && !(send_q[0].hold && avg_q.size() != 0)) begin
        nxt = send_q.pop_front();
        in_valid  <= 1'b1;
        in_action <= nxt.action;
        in_red    <= nxt.red;
        in_green  <= nxt.green;
        in_blue   <= nxt.blue;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result stall: modes of free flow, coin toss, a stall whenever the mode's
  // remaining count is a multiple of three and long runs, each held for a while.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 80);
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      2:       out_stall <= (stall_left % 3 == 0);
      default: out_stall <= ($urandom_range(0, 7) == 0) ? !out_stall : out_stall;
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run after a long stretch with no transfer at all.
  // --------------------------------------------------------------------------
  int idle_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_taken) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic act, input logic [15:0] r, g, b);
    pixel_word_t w;
    w.action = act;
    w.red    = r;
    w.green  = g;
    w.blue   = b;
    w.hold   = ($urandom_range(0, 59) == 0);
    send_q.push_back(w);
  endtask

  // n_px pixels of a dim x dim frame, then n_dr drain words, with words
  // sprinkled in that the block has to ignore.
  task automatic gen_frame(input int unsigned dim, n_px, n_dr);
    for (int unsigned i = 0; i < n_px; i++) begin
      if ($urandom_range(0, 39) == 0) push_word(ACT_DRAIN, rand_chan(), rand_chan(), rand_chan());
      push_word(ACT_PIXEL, rand_chan(), rand_chan(), rand_chan());
    end
    for (int unsigned i = 0; i < n_dr; i++) begin
      if ($urandom_range(0, 11) == 0) push_word(ACT_PIXEL, rand_chan(), rand_chan(), rand_chan());
      push_word(ACT_DRAIN, rand_chan(), rand_chan(), rand_chan());
    end
    if (n_dr == dim && $urandom_range(0, 7) == 0)
      push_word(ACT_DRAIN, rand_chan(), rand_chan(), rand_chan());
    word_total += n_px + n_dr;
  endtask

  // Wait until every word is sent and every result is back, then let the
  // pipeline empty out words that give no result.
  task automatic settle();
    while (send_q.size() != 0 || in_valid || avg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-3:0] idx,
                            input logic [9:0] val);
    logic [31:0] data;
    data       = $urandom;
    data[9:0]  = val;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_taken = 1'b1;
    if (wr)
      size_apply(idx, data[9:0]);
    else if (cfg_prdata !== {22'd0, size_reg})
      flag_error($sformatf("image_size read: exp %h, got %h", {22'd0, size_reg}, cfg_prdata));
    @(negedge clk);
    cfg_taken    = 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [9:0]  sz;
    int unsigned dim;
    int          nfr;
    int          mode;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the frame size.
    cfg_access(1'b0, REG_IMAGE_SIZE, '0);

    // Directed: smallest frame through a size below the minimum, channel
    // extremes, drain with nothing pending and pixel during the drain.
    cfg_access(1'b1, REG_IMAGE_SIZE, 10'd0);
    cfg_access(1'b0, REG_IMAGE_SIZE, '0);
    push_word(ACT_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(ACT_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(ACT_PIXEL, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_PIXEL, 16'hFFFF, 16'h0000, 16'h8000);
    push_word(ACT_PIXEL, 16'h0001, 16'hFFFF, 16'h7FFF);
    push_word(ACT_PIXEL, 16'hAAAA, 16'h5555, 16'hFFFF);
    push_word(ACT_DRAIN, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_DRAIN, 16'h0000, 16'h0000, 16'h0000);
    push_word(ACT_DRAIN, 16'h0000, 16'h0000, 16'h0000);
    word_total += 6;
    settle();

    // A write to an unknown register leaves the frame size alone.
    cfg_access(1'b1, REG_UNUSED, 10'd5);
    cfg_access(1'b0, REG_IMAGE_SIZE, '0);
    settle();

    // Directed 3x3 frame: corners, edges and the full center window.
    cfg_access(1'b1, REG_IMAGE_SIZE, 10'd3);
    for (int i = 0; i < 9; i++)
      push_word(ACT_PIXEL, (i % 2 == 1) ? 16'hFFFF : 16'h0000,
                (i % 3 == 0) ? 16'hFFFF : 16'h0001, 16'h8000 >> i);
    for (int i = 0; i < 3; i++) push_word(ACT_DRAIN, 16'hFFFF, 16'h0000, 16'hFFFF);
    word_total += 12;
    settle();

    // Largest frame through a size above the maximum: one full row plus the
    // start of the second, cut short by the next size write.
    cfg_access(1'b1, REG_IMAGE_SIZE, 10'h3FF);
    cfg_access(1'b0, REG_IMAGE_SIZE, '0);
    gen_frame(LINE_MAX, LINE_MAX + 24, 0);
    settle();

    // Random phases on small frames, some cut short while filling or draining.
    while (word_total < ITEM_TARGET) begin
      case ($urandom_range(0, 15))
        0:       sz = 10'd0;
        1:       sz = 10'd1;
        2:       sz = 10'd2;
        3:       sz = 10'($urandom_range(10, 12));
        default: sz = 10'($urandom_range(3, 9));
      endcase
      cfg_access(1'b1, REG_IMAGE_SIZE, sz);
      if ($urandom_range(0, 3) == 0) cfg_access(1'b0, REG_IMAGE_SIZE, '0);
      dim = clamp_dim(sz);
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
          gen_frame(dim, $urandom_range(1, dim * dim - 1), 0);
          break;
        end else if (mode == 1) begin
          gen_frame(dim, dim * dim, $urandom_range(0, dim - 1));
          break;
        end
        gen_frame(dim, dim * dim, dim);
      end
      settle();
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
